### hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the LRU key-value cache
// Field widths, command codes, reset values and the store control bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // Default depth of the cache
   localparam int DEFAULT_MAX_ENTRIES = 16;

   // Payload widths
   localparam int KEY_W      = 32;
   localparam int VALUE_W    = 32;
   localparam int CAP_W      = 5;
   localparam int REQ_DATA_W = KEY_W + VALUE_W;
   localparam int RSP_DATA_W = VALUE_W;

   // Command codes carried in req_tuser
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Capacity register reset value
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Value returned by a get that misses
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   // Strobes from the controller to the entry store
   typedef struct packed {
      logic rd_en;     // read key, value and rank at rd_addr
      logic kv_we;     // write key and value at kv_addr
      logic rank_we;   // write rank at rank_addr
   } store_ctrl_type;

endpackage

### hdl/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store: entry memories of the LRU key-value cache
// One memory holds key and value per entry, a second one the recency rank.
// Each has one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkvc_store #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES,
   parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                         clock,
   input  lkvc_pkg::store_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]             rd_addr,
   input  logic [IDX_W-1:0]             kv_addr,
   input  logic [IDX_W-1:0]             rank_addr,
   input  logic [lkvc_pkg::KEY_W-1:0]   wr_key,
   input  logic [lkvc_pkg::VALUE_W-1:0] wr_value,
   input  logic [IDX_W-1:0]             wr_rank,
   output logic [lkvc_pkg::KEY_W-1:0]   rd_key,
   output logic [lkvc_pkg::VALUE_W-1:0] rd_value,
   output logic [IDX_W-1:0]             rd_rank
);
   import lkvc_pkg::*;

   logic [KEY_W+VALUE_W-1:0] kv_mem [MAX_ENTRIES];
   logic [IDX_W-1:0]         rank_mem [MAX_ENTRIES];
   logic [KEY_W+VALUE_W-1:0] kv_rd_ff;
   logic [IDX_W-1:0]         rank_rd_ff;

   // Key/value memory
   always_ff @(posedge clock) begin
      if (ctrl.kv_we) begin
         kv_mem[kv_addr] <= {wr_value, wr_key};
      end
      if (ctrl.rd_en) begin
         kv_rd_ff <= kv_mem[rd_addr];
      end
   end

   // Rank memory
   always_ff @(posedge clock) begin
      if (ctrl.rank_we) begin
         rank_mem[rank_addr] <= wr_rank;
      end
      if (ctrl.rd_en) begin
         rank_rd_ff <= rank_mem[rd_addr];
      end
   end

   assign rd_key   = kv_rd_ff[KEY_W-1:0];
   assign rd_value = kv_rd_ff[KEY_W+VALUE_W-1:KEY_W];
   assign rd_rank  = rank_rd_ff;

endmodule

### hdl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, LRU replacement
// Serves get and put requests; a get returns one response, a put none.
// ----------------------------------------------------------------------------
// Usage: the cache works on one request at a time. Each request sweeps the
// entry memories once to compare the key against every entry (one memory
// read per entry), then decides, and for a hit or a put sweeps the rank
// memory again to age the younger entries (one read-modify-write per
// entry), then returns to idle with ready high. The single read port of the
// entry memories makes each sweep go one entry at a time. A finished
// response waits in an output register, so the next request is taken while
// it is still pending; a get holds in the decide state for as long as the
// previous response has not yet left.
// Valid bits live in flip-flops, so no clearing pass follows reset.
// Capacity is to be changed through csr_we/csr_wdata only while the cache
// is idle; the cache itself does not enforce this.
module lru_key_value_cache_unit #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   // capacity register
   input  logic                            csr_we,
   input  logic [lkvc_pkg::CAP_W-1:0]      csr_wdata,   // capacity_in_use
   // requests
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lkvc_pkg::REQ_DATA_W-1:0] req_tdata,   // key [31:0], value [63:32]
   input  logic                            req_tuser,   // cmd
   // responses
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lkvc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // read_value [31:0]
   output logic                            rsp_tuser    // found
);
   import lkvc_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CMP_W-1:0] MAX_CMP  = CMP_W'(MAX_ENTRIES);
   localparam logic [CMP_W-1:0] ONE_CMP  = CMP_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_TOUCH
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CAP_W-1:0]       cap_ff;
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]       used_ff;

   // request being served
   logic                   cmd_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [VALUE_W-1:0]     value_ff;

   // scan results
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_slot_ff;
   logic [IDX_W-1:0]       hit_rank_ff;
   logic [VALUE_W-1:0]     hit_value_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_slot_ff;
   logic                   lru_found_ff;
   logic [IDX_W-1:0]       lru_slot_ff;
   logic [IDX_W-1:0]       lru_rank_ff;

   // touch target
   logic [IDX_W-1:0]       tgt_slot_ff;
   logic [IDX_W-1:0]       old_rank_ff;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_found_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;

   // store interface
   store_ctrl_type         st_ctrl;
   logic [IDX_W-1:0]       st_rd_addr;
   logic [IDX_W-1:0]       st_kv_addr;
   logic [IDX_W-1:0]       st_rank_wdata;
   logic [KEY_W-1:0]       st_rd_key;
   logic [VALUE_W-1:0]     st_rd_value;
   logic [IDX_W-1:0]       st_rd_rank;

   // derived control
   logic                   req_xfer;
   logic                   rsp_free;
   logic                   rsp_post;
   logic                   proc_active;
   logic [IDX_W-1:0]       proc_idx;
   logic                   proc_valid;
   logic [CMP_W-1:0]       cap_cmp;
   logic [CMP_W-1:0]       eff_cap;
   logic                   cache_full;
   logic                   put_hit;
   logic                   put_fill;
   logic                   put_evict;
   logic                   age_entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // a get loads the response register in this cycle
   assign rsp_post   = (state_ff == ST_DECIDE) && (cmd_ff == CMD_GET) && rsp_free;

   // entry whose memory data is on the read outputs this cycle
   assign proc_active = (cnt_ff != '0);
   assign proc_idx    = IDX_W'(cnt_ff - CNT_W'(1));
   assign proc_valid  = valid_ff[proc_idx];

   // capacity clamped to 1..MAX_ENTRIES
   assign cap_cmp    = CMP_W'(cap_ff);
   assign eff_cap    = (cap_cmp == '0) ? ONE_CMP : ((cap_cmp > MAX_CMP) ? MAX_CMP : cap_cmp);
   assign cache_full = (CMP_W'(used_ff) >= eff_cap);

   // put outcome, valid in ST_DECIDE
   assign put_hit   = (cmd_ff == CMD_PUT) && hit_ff;
   assign put_fill  = (cmd_ff == CMD_PUT) && !hit_ff && !cache_full && free_found_ff;
   assign put_evict = (cmd_ff == CMD_PUT) && !hit_ff && cache_full && lru_found_ff;

   // entry ages when it is younger than the touched one
   assign age_entry = proc_valid && (st_rd_rank < old_rank_ff);

   // memory strobes and addresses
   always_comb begin
      st_ctrl.rd_en   = ((state_ff == ST_SCAN) || (state_ff == ST_TOUCH)) && (cnt_ff < LAST_CNT);
      st_ctrl.kv_we   = (state_ff == ST_DECIDE) && (put_hit || put_fill || put_evict);
      st_ctrl.rank_we = (state_ff == ST_TOUCH) && proc_active &&
                        ((proc_idx == tgt_slot_ff) || age_entry);
      st_rd_addr      = cnt_ff[IDX_W-1:0];
      st_kv_addr      = put_hit ? hit_slot_ff : (put_fill ? free_slot_ff : lru_slot_ff);
      st_rank_wdata   = (proc_idx == tgt_slot_ff) ? '0 : (st_rd_rank + IDX_W'(1));
   end

   lkvc_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_store (
      .clock     (clock),
      .ctrl      (st_ctrl),
      .rd_addr   (st_rd_addr),
      .kv_addr   (st_kv_addr),
      .rank_addr (proc_idx),
      .wr_key    (key_ff),
      .wr_value  (value_ff),
      .wr_rank   (st_rank_wdata),
      .rd_key    (st_rd_key),
      .rd_value  (st_rd_value),
      .rd_rank   (st_rd_rank)
   );

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // controller and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         valid_ff      <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         lru_found_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_post) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  cmd_ff        <= req_tuser;
                  key_ff        <= req_tdata[KEY_W-1:0];
                  value_ff      <= req_tdata[REQ_DATA_W-1:KEY_W];
                  hit_ff        <= 1'b0;
                  free_found_ff <= 1'b0;
                  lru_found_ff  <= 1'b0;
                  cnt_ff        <= '0;
                  state_ff      <= ST_SCAN;
               end
            end

            // compare every entry against the key, track a free and the oldest slot
            ST_SCAN: begin
               if (proc_active) begin
                  if (proc_valid && (st_rd_key == key_ff) && !hit_ff) begin
                     hit_ff       <= 1'b1;
                     hit_slot_ff  <= proc_idx;
                     hit_rank_ff  <= st_rd_rank;
                     hit_value_ff <= st_rd_value;
                  end
                  if (!proc_valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= proc_idx;
                  end
                  if (proc_valid && (!lru_found_ff || (st_rd_rank > lru_rank_ff))) begin
                     lru_found_ff <= 1'b1;
                     lru_slot_ff  <= proc_idx;
                     lru_rank_ff  <= st_rd_rank;
                  end
               end
               if (cnt_ff == LAST_CNT) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end

            // pick the target slot; gets post their response here
            ST_DECIDE: begin
               cnt_ff <= '0;
               if (cmd_ff == CMD_GET) begin
                  if (rsp_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_found_ff <= hit_ff;
                     rsp_value_ff <= hit_ff ? hit_value_ff : MISS_VALUE;
                     tgt_slot_ff  <= hit_slot_ff;
                     old_rank_ff  <= hit_rank_ff;
                     state_ff     <= hit_ff ? ST_TOUCH : ST_IDLE;
                  end
               end else if (put_hit) begin
                  tgt_slot_ff <= hit_slot_ff;
                  old_rank_ff <= hit_rank_ff;
                  state_ff    <= ST_TOUCH;
               end else if (put_fill) begin
                  tgt_slot_ff            <= free_slot_ff;
                  old_rank_ff            <= IDX_W'(used_ff);
                  valid_ff[free_slot_ff] <= 1'b1;
                  used_ff                <= used_ff + CNT_W'(1);
                  state_ff               <= ST_TOUCH;
               end else if (put_evict) begin
                  tgt_slot_ff <= lru_slot_ff;
                  old_rank_ff <= lru_rank_ff;
                  state_ff    <= ST_TOUCH;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end

            // rank update sweep, writes happen through the store strobes
            ST_TOUCH: begin
               if (cnt_ff == LAST_CNT) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_found_ff;

   // entry count matches the valid bits
   a_used_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(used_ff))
      else $error("entry count differs from number of valid entries");

   // never more entries than slots
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= MAX_ENTRIES)
      else $error("entry count above depth");

   // a fill always finds a free slot
   a_fill_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && (cmd_ff == CMD_PUT) && !hit_ff && !cache_full
      |-> free_found_ff)
      else $error("fill without free slot");

   // an accepted request starts a key scan from entry zero
   a_xfer_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("request transfer did not start a scan");

   // a miss response always carries the miss value
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_value_ff == MISS_VALUE))
      else $error("miss response with stored value");

endmodule

### dv/tb_lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit: self-checking bench for the LRU key-value cache
// A directed table covers key and value extremes, value updates, misses and
// odd capacity settings. Random phases follow, each at its own capacity, with
// keys drawn from a small pool so that hits, fills and evictions all occur.
// Each response is checked against a cycle-free model of the cache or a typed row value.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int DEPTH        = DEFAULT_MAX_ENTRIES;
   // Worst request latency (hit or put) plus margin
   localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
   localparam int N_PHASES     = 9;
   localparam int PHASE_ITEMS  = 120;
   localparam int N_ROWS       = 24;
   localparam int POOL_MAX     = 20;

   typedef struct packed {
      logic                found;
      logic [VALUE_W-1:0]  value;
   } lookup_rsp_t;

   typedef enum logic [1:0] {
      ROW_REQ,       // request, response predicted
      ROW_CHECKED,   // request, response typed in the row
      ROW_CAP        // capacity write
   } row_kind_t;

   typedef struct packed {
      row_kind_t           kind;
      logic                cmd;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  val;
      logic [CAP_W-1:0]    cap;
      logic                found;
      logic [VALUE_W-1:0]  rd_val;
   } dir_row_t;

   // DUT signals; the inputs are all known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CAP_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // key [31:0], value [63:32]
   logic                  req_tuser  = 1'b0; // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // read_value [31:0]
   logic                  rsp_tuser;          // found

   lru_key_value_cache_unit #(.MAX_ENTRIES(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Shadow copy of the cache contents
   logic [KEY_W-1:0]   shadow_key  [DEPTH];
   logic [VALUE_W-1:0] shadow_val  [DEPTH];
   logic               shadow_vld  [DEPTH];
   logic [3:0]         shadow_rank [DEPTH];
   logic [4:0]         shadow_used = '0;
   logic [CAP_W-1:0]   shadow_cap  = CAP_RESET;

   lookup_rsp_t lookups_pending [$];

   int mismatches = 0;
   int gets_sent  = 0;
   int puts_sent  = 0;
   int hits_seen  = 0;
   int misses_seen = 0;
   int cap_writes = 0;
   int idle_odds  = 0;   // 0: no idling, n: a burst starts with odds of one in n
   int rsp_hold   = 0;

   dir_row_t         directed_rows [N_ROWS];
   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int               pool_len;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         shadow_vld[i]  = 1'b0;
         shadow_rank[i] = '0;
         shadow_key[i]  = '0;
         shadow_val[i]  = '0;
      end
   end

   task automatic log_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic int effective_capacity();
      if (shadow_cap == 0)
         return 1;
      if (shadow_cap > DEPTH)
         return DEPTH;
      return int'(shadow_cap);
   endfunction

   // Slot holding the key, -1 when absent
   function automatic int slot_of(input logic [KEY_W-1:0] k);
      for (int i = 0; i < DEPTH; i++)
         if (shadow_vld[i] && shadow_key[i] == k)
            return i;
      return -1;
   endfunction

   // Slot s becomes most recent; valid entries younger than it age by one
   function automatic void make_newest(input int s);
      logic [3:0] old_rank;
      old_rank = shadow_rank[s];
      for (int i = 0; i < DEPTH; i++)
         if (shadow_vld[i] && i != s && shadow_rank[i] < old_rank)
            shadow_rank[i] = shadow_rank[i] + 4'd1;
      shadow_rank[s] = '0;
   endfunction

   // One cache access: updates the shadow and gives the response of a get
   function automatic void cache_access(input logic cmd, input logic [KEY_W-1:0] k,
                                        input logic [VALUE_W-1:0] v,
                                        output bit has_rsp, output lookup_rsp_t rsp);
      int s;
      int free_slot;
      s = slot_of(k);
      has_rsp = 1'b0;
      rsp = '0;
      if (cmd == CMD_GET) begin
         has_rsp = 1'b1;
         if (s >= 0) begin
            rsp = '{found: 1'b1, value: shadow_val[s]};
            make_newest(s);
         end else begin
            rsp = '{found: 1'b0, value: MISS_VALUE};
         end
      end else if (s >= 0) begin
         // update in place
         shadow_val[s] = v;
         make_newest(s);
      end else if (int'(shadow_used) < effective_capacity()) begin
         // fill the lowest free slot, starting as the oldest
         free_slot = -1;
         for (int i = DEPTH - 1; i >= 0; i--)
            if (!shadow_vld[i])
               free_slot = i;
         if (free_slot >= 0) begin
            shadow_vld[free_slot]  = 1'b1;
            shadow_key[free_slot]  = k;
            shadow_val[free_slot]  = v;
            shadow_rank[free_slot] = shadow_used[3:0];
            shadow_used = shadow_used + 5'd1;
            make_newest(free_slot);
         end
      end else begin
         // evict the oldest valid entry, first slot wins a tie
         s = -1;
         for (int i = 0; i < DEPTH; i++)
            if (shadow_vld[i] && (s < 0 || shadow_rank[i] > shadow_rank[s]))
               s = i;
         if (s >= 0) begin
            shadow_key[s] = k;
            shadow_val[s] = v;
            make_newest(s);
         end
      end
   endfunction

   // One request transfer; typed_rsp replaces the prediction when use_typed is set
   task automatic issue(input logic cmd, input logic [KEY_W-1:0] k,
                        input logic [VALUE_W-1:0] v, input bit use_typed,
                        input lookup_rsp_t typed_rsp);
      bit          has_rsp;
      lookup_rsp_t rsp;
      int          gap;
      @(negedge clock);
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {v, k};
      do @(posedge clock); while (!req_tready);
      cache_access(cmd, k, v, has_rsp, rsp);
      if (has_rsp)
         lookups_pending.push_back(use_typed ? typed_rsp : rsp);
      if (cmd == CMD_GET)
         gets_sent++;
      else
         puts_sent++;
   endtask

   // Capacity write once the cache has gone quiet
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lookups_pending.size() != 0) @(negedge clock);
      // a trailing put gives no response, so let it finish
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_cap = cap;
      cap_writes++;
   endtask

   // Response ready with random stall bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (!reset && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         rsp_hold = $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response check against the oldest expectation
   always @(posedge clock) begin : rsp_check
      lookup_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser)
            hits_seen++;
         else
            misses_seen++;
         if (lookups_pending.size() == 0) begin
            log_mismatch($sformatf("response with none expected: found %0b value %h",
                                   rsp_tuser, rsp_tdata));
         end else begin
            want = lookups_pending.pop_front();
            if (rsp_tuser !== want.found)
               log_mismatch($sformatf("found %0b, expected %0b", rsp_tuser, want.found));
            if (rsp_tdata !== want.value)
               log_mismatch($sformatf("read_value %h, expected %h", rsp_tdata, want.value));
         end
      end
   end

   // Run time limit
   initial begin
      #2ms;
      $display("FAIL lru_key_value_cache_unit");
      $finish;
   end

   initial begin : stimulus
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      logic               cmd;
      logic [CAP_W-1:0]   phase_caps [N_PHASES];
      int                 phase_odds [N_PHASES];

      phase_caps = '{5'd16, 5'd1, 5'd6, 5'd31, 5'd3, 5'd0, 5'd11, 5'd16, 5'd8};
      phase_odds = '{4, 0, 2, 3, 0, 4, 2, 3, 0};

      // kind, cmd, key, value, capacity, expected found, expected read_value
      directed_rows = '{
         '{ROW_CHECKED, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, MISS_VALUE},
         '{ROW_REQ,     CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0, 1'b0, 32'h0},
         '{ROW_CHECKED, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 32'h8000_0000},
         '{ROW_REQ,     CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0, 1'b0, 32'h0},
         '{ROW_CHECKED, CMD_GET, 32'h8000_0000, 32'h0000_0000, 5'd0, 1'b1, 32'h7FFF_FFFF},
         '{ROW_REQ,     CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b0, 32'h0},
         '{ROW_CHECKED, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 32'hFFFF_FFFF},
         '{ROW_REQ,     CMD_PUT, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 32'h0},
         '{ROW_CHECKED, CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, 32'h0000_0000},
         // value update of a present key
         '{ROW_REQ,     CMD_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 5'd0, 1'b0, 32'h0},
         '{ROW_CHECKED, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 32'h5A5A_5A5A},
         '{ROW_CHECKED, CMD_GET, 32'h0000_0001, 32'hFFFF_FFFF, 5'd0, 1'b0, MISS_VALUE},
         // capacity lowered below the entries held: puts of new keys evict
         '{ROW_CAP,     CMD_GET, 32'h0,         32'h0,         5'd2, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_PUT, 32'h0000_0001, 32'hA5A5_A5A5, 5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_GET, 32'h8000_0000, 32'h0,         5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_GET, 32'hFFFF_FFFF, 32'h0,         5'd0, 1'b0, 32'h0},
         // zero capacity acts as one
         '{ROW_CAP,     CMD_GET, 32'h0,         32'h0,         5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_PUT, 32'h0000_0002, 32'h0000_0001, 5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_GET, 32'h0000_0002, 32'h0,         5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_GET, 32'h0000_0000, 32'h0,         5'd0, 1'b0, 32'h0},
         // capacity above the depth saturates
         '{ROW_CAP,     CMD_GET, 32'h0,         32'h0,         5'd31, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_PUT, 32'h1234_5678, 32'h8765_4321, 5'd0, 1'b0, 32'h0},
         '{ROW_REQ,     CMD_GET, 32'h1234_5678, 32'h0,         5'd0, 1'b0, 32'h0},
         '{ROW_CAP,     CMD_GET, 32'h0,         32'h0,         5'd16, 1'b0, 32'h0}
      };

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed table
      idle_odds = 3;
      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_CAP: begin
               write_capacity(directed_rows[r].cap);
            end
            ROW_CHECKED: begin
               issue(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].val, 1'b1,
                     '{found: directed_rows[r].found, value: directed_rows[r].rd_val});
            end
            default: begin
               issue(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].val,
                     1'b0, '0);
            end
         endcase
      end

      // random phases, each with its own capacity and a key pool a little larger
      for (int p = 0; p < N_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         idle_odds = phase_odds[p];
         pool_len = effective_capacity() + $urandom_range(1, 4);
         for (int i = 0; i < pool_len; i++)
            key_pool[i] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 9) == 0)
               k = $urandom;
            else
               k = key_pool[$urandom_range(0, pool_len - 1)];
            v = $urandom;
            issue(cmd, k, v, 1'b0, '0);
         end
      end

      // drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (lookups_pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d gets (%0d hits, %0d misses) and %0d puts", gets_sent, hits_seen,
               misses_seen, puts_sent);
      $display("over %0d capacity writes including zero, one, full depth and above", cap_writes);
      if (mismatches == 0)
         $display("PASS lru_key_value_cache_unit");
      else
         $display("FAIL lru_key_value_cache_unit");
      $finish;
   end

endmodule

### sim.f
hdl/lkvc_pkg.sv
hdl/lkvc_store.sv
hdl/lru_key_value_cache_unit.sv
dv/tb_lru_key_value_cache_unit.sv
